// File: sv/chd_pkg.sv
// ----------------------------------------------------------------------------
// chd_pkg
// Shared types and character codes of the chunked body decoder.
// ----------------------------------------------------------------------------
package chd_pkg;

	localparam logic [7:0] CH_CR = 8'd13;
	localparam logic [7:0] CH_LF = 8'd10;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_HT = 8'd9;

	// one raw body byte
	typedef struct packed {
		logic [7:0] body_byte;
		logic       start_of_body;
	} raw_word_t;

	// one decoded result
	typedef struct packed {
		logic [7:0] data_byte;
		logic       chunk_end;
		logic       body_done;
	} dec_word_t;

	// byte classes seen by the state update
	typedef struct packed {
		logic       is_space;
		logic       is_hex;
		logic [3:0] hex_val;
		logic       is_cr;
		logic       is_lf;
	} byte_class_t;

endpackage

// File: sv/chd_stream_if.sv
// ----------------------------------------------------------------------------
// chd_stream_if
// Valid/ready stream channel carrying one word of a chosen payload type.
// ----------------------------------------------------------------------------
interface chd_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (
		output valid,
		output payload,
		input  ready
	);

	modport sink (
		input  valid,
		input  payload,
		output ready
	);
endinterface

// File: sv/chd_classify.sv
// ----------------------------------------------------------------------------
// chd_classify
// Sorts one body byte into whitespace, hex digit (with value), CR and LF.
// ----------------------------------------------------------------------------
module chd_classify (
	input  logic [7:0]          body_byte,
	output chd_pkg::byte_class_t cls
);

	always_comb begin
		cls = '0;
		cls.is_cr = (body_byte == chd_pkg::CH_CR);
		cls.is_lf = (body_byte == chd_pkg::CH_LF);
		// space, HT, LF, VT, FF, CR
		cls.is_space = (body_byte == chd_pkg::CH_SPACE) ||
			((body_byte >= chd_pkg::CH_HT) && (body_byte <= chd_pkg::CH_CR));
		if (body_byte >= 8'h30 && body_byte <= 8'h39) begin
			cls.is_hex = 1'b1;
			cls.hex_val = body_byte[3:0];
		end else if ((body_byte >= 8'h61 && body_byte <= 8'h66) ||
			(body_byte >= 8'h41 && body_byte <= 8'h46)) begin
			cls.is_hex = 1'b1;
			cls.hex_val = body_byte[3:0] + 4'd9;
		end
	end

endmodule

// File: sv/chd_core.sv
// ----------------------------------------------------------------------------
// chd_core
// Decoder state and result register: one state update per processed byte.
// ----------------------------------------------------------------------------
module chd_core #(
	parameter int LEN_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  chd_pkg::raw_word_t   item,
	input  chd_pkg::byte_class_t cls,
	input  logic                 res_take,
	output logic                 res_valid_q,
	output chd_pkg::dec_word_t   res_q
);

	typedef enum logic [2:0] {
		PH_SKIP    = 3'd0,
		PH_DIGITS  = 3'd1,
		PH_IGNORE  = 3'd2,
		PH_DATA    = 3'd3,
		PH_TRAILER = 3'd4,
		PH_DONE    = 3'd5
	} phase_t;

	phase_t              phase_q, phase_cur, phase_n;
	logic                cr_q, cr_cur, cr_n;
	logic [LEN_BITS-1:0] len_q, len_cur, len_n, len_add;
	logic                trl_q, trl_cur, trl_n;
	logic                has_res;
	chd_pkg::dec_word_t  res_n;

	// shift in one digit, saturating once the top nibble is occupied
	assign len_add = (|len_cur[LEN_BITS-1 -: 4]) ? {LEN_BITS{1'b1}} :
		{len_cur[LEN_BITS-5:0], cls.hex_val};

	always_comb begin
		phase_cur = item.start_of_body ? PH_SKIP : phase_q;
		cr_cur    = item.start_of_body ? 1'b0 : cr_q;
		len_cur   = item.start_of_body ? '0 : len_q;
		trl_cur   = item.start_of_body ? 1'b0 : trl_q;
		phase_n = phase_cur;
		cr_n    = cr_cur;
		len_n   = len_cur;
		trl_n   = trl_cur;
		has_res = 1'b0;
		res_n   = '0;
		case (phase_cur)
			PH_SKIP, PH_DIGITS, PH_IGNORE: begin
				if (cr_cur && cls.is_lf) begin
					cr_n = 1'b0;
					if (len_cur == '0) begin
						phase_n = PH_DONE;
						has_res = 1'b1;
						res_n.body_done = 1'b1;
					end else begin
						phase_n = PH_DATA;
					end
				end else begin
					cr_n = cls.is_cr;
					if (phase_cur == PH_SKIP) begin
						if (!cls.is_space) begin
							if (cls.is_hex) begin
								len_n = len_add;
								phase_n = PH_DIGITS;
							end else begin
								phase_n = PH_IGNORE;
							end
						end
					end else if (phase_cur == PH_DIGITS) begin
						if (cls.is_hex) begin
							len_n = len_add;
						end else begin
							phase_n = PH_IGNORE;
						end
					end
				end
			end
			PH_DATA: begin
				len_n = len_cur - 1'b1;
				has_res = 1'b1;
				res_n.data_byte = item.body_byte;
				if (len_n == '0) begin
					res_n.chunk_end = 1'b1;
					phase_n = PH_TRAILER;
					trl_n = 1'b0;
				end
			end
			PH_TRAILER: begin
				// drop two bytes unchecked
				if (trl_cur) begin
					trl_n = 1'b0;
					phase_n = PH_SKIP;
					cr_n = 1'b0;
					len_n = '0;
				end else begin
					trl_n = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SKIP;
			cr_q        <= 1'b0;
			len_q       <= '0;
			trl_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (step) begin
				phase_q     <= phase_n;
				cr_q        <= cr_n;
				len_q       <= len_n;
				trl_q       <= trl_n;
				res_valid_q <= has_res;
				if (has_res) begin
					res_q <= res_n;
				end
			end else if (res_take) begin
				res_valid_q <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_data_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> len_q != '0)
		else $error("data phase with zero remaining length");

	a_done_phase: assert property (@(posedge clk) disable iff (!arst_n)
		step && has_res && res_n.body_done |=> phase_q == PH_DONE && res_valid_q)
		else $error("end marker did not finish the body");

	a_chunk_end_len: assert property (@(posedge clk) disable iff (!arst_n)
		step && has_res && res_n.chunk_end |=> phase_q == PH_TRAILER && len_q == '0)
		else $error("chunk end without trailer phase");

	a_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.body_done |-> res_q.data_byte == 8'd0 && !res_q.chunk_end)
		else $error("end marker carries data");
`endif

endmodule

// File: sv/http_chunked_body_decoder_top.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_top
// Strips the chunk size lines from a chunked HTTP body, one byte per word.
//
// Takes one body byte per cycle unless the output stalls, and gives the
// payload bytes of each chunk, with chunk_end on the last byte of a chunk and
// one body_done word (data 0) when the zero-size line ends. The accepted byte
// is held in an input register; the combinational state update writes the
// result register. Sustained rate is one byte per cycle while the output
// takes words, set by the combinational update of phase and chunk length;
// size lines and the two bytes after each chunk give no output; bytes after
// body_done are dropped until start_of_body on a word clears the decoder.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_top #(
	parameter int LEN_BITS = 32
) (
	input logic        clk,
	input logic        arst_n,
	chd_stream_if.sink   raw,
	chd_stream_if.source decoded
);

	logic                 valid_s1;
	chd_pkg::raw_word_t   item_s1;
	chd_pkg::byte_class_t cls;
	logic                 advance;
	logic                 res_valid_q;
	chd_pkg::dec_word_t   res_q;

	// move the held byte on whenever the result register can take a word
	assign advance   = valid_s1 && (decoded.ready || !res_valid_q);
	assign raw.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			if (raw.valid && raw.ready) begin
				valid_s1 <= 1'b1;
				item_s1  <= raw.payload;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	chd_classify u_classify (
		.body_byte (item_s1.body_byte),
		.cls       (cls)
	);

	chd_core #(
		.LEN_BITS (LEN_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.item        (item_s1),
		.cls         (cls),
		.res_take    (decoded.ready),
		.res_valid_q (res_valid_q),
		.res_q       (res_q)
	);

	assign decoded.valid   = res_valid_q;
	assign decoded.payload = res_q;

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the chunked HTTP body decoder.
//
// Feeds short directed bodies, then random chunked bodies with broken ones
// mixed in. A local copy of the decoder predicts every payload word at the
// input handshake, and the output side checks each word field by field
// against the oldest prediction. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int LEN_BITS = 32;
	localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};
	localparam logic [7:0] CH_VT = 8'd11;
	localparam logic [7:0] CH_FF = 8'd12;
	localparam int IDLE_PCT = 29;
	localparam int STALL_LIMIT = 2000;
	localparam int BODY_BYTES = 1550;

	typedef enum logic [2:0] {
		PH_SKIP, PH_DIGITS, PH_IGNORE, PH_DATA, PH_TRAILER, PH_DONE
	} body_phase_t;

	typedef struct {
		chd_pkg::raw_word_t w;
		bit                 drain;
	} queued_byte_t;

	logic clk = 1'b0;
	logic arst_n;

	chd_stream_if #(.payload_t(chd_pkg::raw_word_t)) raw_if ();
	chd_stream_if #(.payload_t(chd_pkg::dec_word_t)) dec_if ();

	http_chunked_body_decoder_top #(.LEN_BITS(LEN_BITS)) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.raw     (raw_if),
		.decoded (dec_if)
	);

	always #5 clk = ~clk;

	queued_byte_t       body_bytes_q[$];
	chd_pkg::dec_word_t due_words[$];
	int                 accepted_count = 0;
	int                 error_count = 0;
	int                 stall_cycles = 0;
	bit                 start_next = 0;
	bit                 drain_next = 0;
	logic               calm;

	// decoder state as seen by the bench
	body_phase_t         dec_phase = PH_SKIP;
	bit                  cr_seen = 0;
	logic [LEN_BITS-1:0] len_left = '0;
	bit                  trail_cnt = 0;

	assign calm = accepted_count >= 900 && accepted_count < 1150;

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------
	function automatic bit is_white(logic [7:0] c);
		return c == chd_pkg::CH_SPACE || (c >= chd_pkg::CH_HT && c <= chd_pkg::CH_CR);
	endfunction

	function automatic bit hex_digit(input logic [7:0] c, output logic [3:0] v);
		v = '0;
		if (c >= "0" && c <= "9") begin
			v = 4'(c - "0");
			return 1;
		end
		if (c >= "a" && c <= "f") begin
			v = 4'(c - "a" + 8'd10);
			return 1;
		end
		if (c >= "A" && c <= "F") begin
			v = 4'(c - "A" + 8'd10);
			return 1;
		end
		return 0;
	endfunction

	function automatic void decode_body_byte(chd_pkg::raw_word_t w);
		chd_pkg::dec_word_t r;
		logic [3:0]         nib;
		bit                 hex_ok;
		if (w.start_of_body) begin
			dec_phase = PH_SKIP;
			cr_seen = 0;
			len_left = '0;
			trail_cnt = 0;
		end
		r = '0;
		case (dec_phase)
		PH_SKIP, PH_DIGITS, PH_IGNORE: begin
			if (cr_seen && w.body_byte == chd_pkg::CH_LF) begin
				cr_seen = 0;
				if (len_left == 0) begin
					dec_phase = PH_DONE;
					r.body_done = 1'b1;
					due_words = {due_words, r};
				end else begin
					dec_phase = PH_DATA;
				end
			end else begin
				cr_seen = (w.body_byte == chd_pkg::CH_CR);
				hex_ok = hex_digit(w.body_byte, nib);
				if ((dec_phase == PH_SKIP && !is_white(w.body_byte))
						|| dec_phase == PH_DIGITS) begin
					if (hex_ok) begin
						// saturate instead of wrapping
						if (len_left > (LEN_MAX >> 4))
							len_left = LEN_MAX;
						else
							len_left = (len_left << 4) + nib;
						dec_phase = PH_DIGITS;
					end else begin
						dec_phase = PH_IGNORE;
					end
				end
			end
		end
		PH_DATA: begin
			len_left = len_left - 1'b1;
			r.data_byte = w.body_byte;
			if (len_left == 0) begin
				r.chunk_end = 1'b1;
				dec_phase = PH_TRAILER;
				trail_cnt = 0;
			end
			due_words = {due_words, r};
		end
		PH_TRAILER: begin
			if (trail_cnt) begin
				trail_cnt = 0;
				dec_phase = PH_SKIP;
				cr_seen = 0;
				len_left = '0;
			end else begin
				trail_cnt = 1;
			end
		end
		default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// stimulus building
	// ------------------------------------------------------------------
	function automatic void put_byte(logic [7:0] b);
		queued_byte_t q;
		q.w.body_byte = b;
		q.w.start_of_body = start_next;
		q.drain = drain_next;
		start_next = 0;
		drain_next = 0;
		body_bytes_q = {body_bytes_q, q};
	endfunction

	function automatic void put_text(string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i]);
	endfunction

	function automatic void put_crlf();
		put_byte(chd_pkg::CH_CR);
		put_byte(chd_pkg::CH_LF);
	endfunction

	function automatic logic [7:0] hex_char(int unsigned v);
		if (v < 10)
			return 8'("0" + v);
		return 8'(($urandom_range(1) ? "A" : "a") + v - 10);
	endfunction

	function automatic logic [7:0] pick_white();
		case ($urandom_range(4))
		0: return chd_pkg::CH_SPACE;
		1: return chd_pkg::CH_HT;
		2: return chd_pkg::CH_LF;
		3: return CH_VT;
		default: return CH_FF;
		endcase
	endfunction

	function automatic void put_size_line(int unsigned size);
		int unsigned nd;
		repeat ($urandom_range(2)) put_byte(pick_white());
		if ($urandom_range(7) == 0) begin
			// CR without LF is only whitespace here
			put_byte(chd_pkg::CH_CR);
			put_byte(chd_pkg::CH_SPACE);
		end
		if ($urandom_range(3) == 0)
			repeat ($urandom_range(1, 2)) put_byte("0");
		nd = 1;
		while (nd < 8 && (size >> (4 * nd)) != 0)
			nd++;
		for (int i = nd - 1; i >= 0; i--)
			put_byte(hex_char((size >> (4 * i)) & 15));
		case ($urandom_range(5))
		0: put_byte(chd_pkg::CH_SPACE);
		1: begin
			put_byte(";");
			repeat ($urandom_range(5)) put_byte(8'($urandom_range(32, 126)));
		end
		2: begin
			put_byte(chd_pkg::CH_CR);
			put_byte("x");
		end
		default: ;
		endcase
		put_crlf();
	endfunction

	function automatic int unsigned chunk_size();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 70)
			return $urandom_range(1, 8);
		if (r < 95)
			return $urandom_range(9, 40);
		return $urandom_range(41, 300);
	endfunction

	function automatic void put_chunk(int unsigned size);
		put_size_line(size);
		repeat (size) put_byte(8'($urandom_range(255)));
		if ($urandom_range(4) == 0) begin
			put_byte(8'($urandom_range(255)));
			put_byte(8'($urandom_range(255)));
		end else begin
			put_crlf();
		end
	endfunction

	function automatic void put_end_line();
		repeat ($urandom_range(1)) put_byte(pick_white());
		case ($urandom_range(6))
		0: put_text("0");
		1: put_text("000");
		2: ;
		3: put_text("+7");
		4: put_text("0x1f");
		5: put_text("-");
		default: put_text("0;ext");
		endcase
		put_crlf();
		// trailing junk is ignored after the end marker
		repeat ($urandom_range(3)) put_byte(8'($urandom_range(255)));
	endfunction

	function automatic void put_random_body();
		int unsigned k;
		start_next = 1;
		k = $urandom_range(9);
		if (k == 0) begin
			repeat ($urandom_range(4, 24)) put_byte(8'($urandom_range(255)));
		end else if (k == 1) begin
			// long size line: may saturate, then cut short by the next body
			repeat ($urandom_range(1)) put_byte(pick_white());
			put_byte(hex_char($urandom_range(1, 15)));
			repeat ($urandom_range(7, 11)) put_byte(hex_char($urandom_range(15)));
			put_crlf();
			repeat ($urandom_range(2, 8)) put_byte(8'($urandom_range(255)));
		end else begin
			repeat ($urandom_range(4)) put_chunk(chunk_size());
			if (k == 2) begin
				put_size_line($urandom_range(5, 20));
				repeat ($urandom_range(4)) put_byte(8'($urandom_range(255)));
			end else begin
				put_end_line();
			end
		end
	endfunction

	// ------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------
	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		error_count++;
		$display("%0t ns: %s mismatch, got %0h want %0h", $time, what, got, want);
	endtask

	// ------------------------------------------------------------------
	// driver
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		queued_byte_t nxt;
		bit           offer;
		if (arst_n) begin
			if (raw_if.valid && raw_if.ready) begin
				decode_body_byte(raw_if.payload);
				accepted_count++;
			end
			if (!raw_if.valid || raw_if.ready) begin
				offer = body_bytes_q.size() != 0
					&& (calm || $urandom_range(99) >= IDLE_PCT);
				// hold until every predicted word has come out
				if (offer && body_bytes_q[0].drain && due_words.size() != 0)
					offer = 0;
				if (offer) begin
					nxt = body_bytes_q.pop_front();
					raw_if.payload <= nxt.w;
				end
				raw_if.valid <= offer;
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		chd_pkg::dec_word_t want;
		chd_pkg::dec_word_t got;
		if (arst_n) begin
			if (dec_if.valid && dec_if.ready) begin
				got = dec_if.payload;
				if (due_words.size() == 0) begin
					report_mismatch("unexpected word", 32'(got), 0);
				end else begin
					want = due_words.pop_front();
					if (got.data_byte !== want.data_byte)
						report_mismatch("data_byte", 32'(got.data_byte),
							32'(want.data_byte));
					if (got.chunk_end !== want.chunk_end)
						report_mismatch("chunk_end", 32'(got.chunk_end),
							32'(want.chunk_end));
					if (got.body_done !== want.body_done)
						report_mismatch("body_done", 32'(got.body_done),
							32'(want.body_done));
				end
			end
			dec_if.ready <= calm || $urandom_range(99) >= IDLE_PCT;
		end
	end

	// ------------------------------------------------------------------
	// watchdog
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if ((raw_if.valid && raw_if.ready) || (dec_if.valid && dec_if.ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t ns: no word moved for %0d cycles", $time, STALL_LIMIT);
				$display("Regression FAIL");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------
	initial begin
		bit drained_mid;
		arst_n = 1'b0;
		raw_if.valid = 1'b0;
		raw_if.payload = '0;
		dec_if.ready = 1'b0;
		drained_mid = 0;

		// bare LF and lone CR while skipping, lone CR ending the digits
		start_next = 1;
		put_byte(chd_pkg::CH_LF);
		put_byte(chd_pkg::CH_CR);
		put_byte(chd_pkg::CH_HT);
		put_byte("2");
		put_byte(chd_pkg::CH_CR);
		put_byte("x");
		put_crlf();
		put_byte(8'h00);
		put_byte(8'hFF);
		// dropped whatever they hold
		put_byte(8'hFF);
		put_byte(8'h00);
		// sign prefix: no digits, ends the body
		put_text("+5");
		put_crlf();
		put_byte(8'hFF);
		// hex prefix reads as zero
		start_next = 1;
		put_text("0x1A");
		put_crlf();
		put_byte("A");

		drain_next = 1;
		while (body_bytes_q.size() < BODY_BYTES) begin
			if (!drained_mid && body_bytes_q.size() >= BODY_BYTES / 2) begin
				drain_next = 1;
				drained_mid = 1;
			end
			put_random_body();
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (body_bytes_q.size() != 0 || raw_if.valid || due_words.size() != 0);
		repeat (8) @(posedge clk);

		if (error_count == 0 && due_words.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
